// ===== sv/slid_pkg.sv =====
// ----------------------------------------------------------------------------
// slid_pkg
// Shared types and constants for the sorted list insert/delete unit.
// ----------------------------------------------------------------------------
package slid_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int DATA_W     = ((VALUE_BITS + 7) / 8) * 8;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]             count_t;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_READ_ASC = 2'd2,
    OP_READ_DSC = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DELETED  = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_ENTRY    = 3'd5
  } status_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_INS    = 3'd1,
    CMD_DEL    = 3'd2,
    CMD_ROT_UP = 3'd3,
    CMD_ROT_DN = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t   cmd;
    value_t operand;
  } cell_ctrl_t;

  typedef struct packed {
    logic   found;
    logic   full;
    value_t head;
    value_t tail;
  } chain_stat_t;

endpackage

// ===== sv/slid_cell.sv =====
// ----------------------------------------------------------------------------
// slid_cell
// One slot of the sorted chain: holds a value and an occupied flag, and
// moves data to/from its neighbors according to the broadcast command.
// ----------------------------------------------------------------------------
module slid_cell import slid_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  value_t     left_val,
  input  logic       left_occ,
  input  logic       left_ge,
  input  value_t     right_val,
  input  logic       right_occ,
  input  value_t     head_val,
  output value_t     val,
  output logic       occ,
  output logic       ge,
  output logic       match
);

  value_t val_next;
  logic   occ_next;

  // Empty slots count as "not below" the operand
  assign ge    = !occ || (val >= ctrl.operand);
  assign match = occ && (val == ctrl.operand);

  always_comb begin
    val_next = val;
    occ_next = occ;
    unique case (ctrl.cmd)
      CMD_INS: begin
        if (ge) begin
          if (!left_ge) begin
            val_next = ctrl.operand;
            occ_next = 1'b1;
          end else begin
            val_next = left_val;
            occ_next = left_occ;
          end
        end
      end
      CMD_DEL: begin
        if (occ && ge) begin
          val_next = right_val;
          occ_next = right_occ;
        end
      end
      CMD_ROT_UP: begin
        // head wraps into the last occupied slot
        if (occ) val_next = right_occ ? right_val : head_val;
      end
      CMD_ROT_DN: begin
        if (occ) val_next = left_val;
      end
      default: begin
        val_next = val;
        occ_next = occ;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

endmodule

// ===== sv/slid_chain.sv =====
// ----------------------------------------------------------------------------
// slid_chain
// Row of DEPTH cells kept in ascending order, with head/tail taps and the
// match summary used by the controller.
// ----------------------------------------------------------------------------
module slid_chain import slid_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_ctrl_t  ctrl,
  output chain_stat_t stat
);

  value_t           vals [DEPTH];
  logic [DEPTH-1:0] occs;
  logic [DEPTH-1:0] ges;
  logic [DEPTH-1:0] hits;
  logic [DEPTH-1:0] is_tail;
  value_t           tail_val;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t lv;
    logic   lo;
    logic   lg;
    value_t rv;
    logic   ro;

    if (i == 0) begin : g_first
      assign lv = tail_val;   // descending rotation wraps the tail to slot 0
      assign lo = 1'b1;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = vals[i-1];
      assign lo = occs[i-1];
      assign lg = ges[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv         = vals[i];
      assign ro         = 1'b0;
      assign is_tail[i] = occs[i];
    end else begin : g_inner
      assign rv         = vals[i+1];
      assign ro         = occs[i+1];
      assign is_tail[i] = occs[i] && !occs[i+1];
    end

    slid_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .left_val  (lv),
      .left_occ  (lo),
      .left_ge   (lg),
      .right_val (rv),
      .right_occ (ro),
      .head_val  (vals[0]),
      .val       (vals[i]),
      .occ       (occs[i]),
      .ge        (ges[i]),
      .match     (hits[i])
    );
  end

  // is_tail is one-hot (or zero when empty): AND-OR select
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_val = tail_val | (vals[i] & {VALUE_BITS{is_tail[i]}});
    end
  end

  assign stat.found = |hits;
  assign stat.full  = occs[DEPTH-1];
  assign stat.head  = vals[0];
  assign stat.tail  = tail_val;

endmodule

// ===== sv/sorted_list_insert_delete_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_unit
// Sorted list of signed values in a chain of cells: insert, delete first
// match, and ascending/descending readout.
//
//   channel  dir  tdata                 tuser        tlast
//   s_*      in   value                 op           -
//   m_*      out  entry_value           status       last
//
// Insert and delete: all cells compare against the operand at once and
// shift by one slot. Readout of n entries: the accept cycle and then one
// chain rotation per result. One input transfer is taken at a time.
// The result register frees the chain: a new item is accepted in the cycle
// its predecessor's result is taken. rst (sync) empties the list.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_unit import slid_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [VALUE_BITS-1:0] value
  input  logic [1:0]        s_tuser,   // [1:0] op
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // [VALUE_BITS-1:0] entry_value
  output logic [2:0]        m_tuser,   // [2:0] status
  output logic              m_tlast
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t      state, state_next;
  count_t      count, count_next;
  count_t      remaining, remaining_next;
  logic        desc, desc_next;
  logic        out_valid, out_valid_next;
  value_t      out_val, out_val_next;
  status_t     out_status, out_status_next;
  logic        out_last, out_last_next;
  cell_ctrl_t  ctrl;
  chain_stat_t stat;
  logic        slot_free;
  op_t         op_in;
  value_t      val_in;

  assign op_in     = op_t'(s_tuser);
  assign val_in    = s_tdata[VALUE_BITS-1:0];
  assign slot_free = !out_valid || m_tready;
  assign s_tready  = (state == S_IDLE) && slot_free;

  slid_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat)
  );

  always_comb begin
    state_next      = state;
    count_next      = count;
    remaining_next  = remaining;
    desc_next       = desc;
    out_valid_next  = out_valid && !m_tready;
    out_val_next    = out_val;
    out_status_next = out_status;
    out_last_next   = out_last;
    ctrl.cmd        = CMD_HOLD;
    ctrl.operand    = val_in;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          out_val_next  = val_in;
          out_last_next = 1'b1;
          unique case (op_in)
            OP_INSERT: begin
              out_valid_next = 1'b1;
              if (stat.full) begin
                out_status_next = ST_FULL;
              end else begin
                ctrl.cmd        = CMD_INS;
                count_next      = count + count_t'(1);
                out_status_next = ST_INSERTED;
              end
            end
            OP_DELETE: begin
              out_valid_next = 1'b1;
              if (stat.found) begin
                ctrl.cmd        = CMD_DEL;
                count_next      = count - count_t'(1);
                out_status_next = ST_DELETED;
              end else begin
                out_status_next = ST_NOTFOUND;
              end
            end
            OP_READ_ASC, OP_READ_DSC: begin
              if (count == '0) begin
                out_valid_next  = 1'b1;
                out_val_next    = '0;
                out_status_next = ST_EMPTY;
              end else begin
                state_next     = S_READ;
                remaining_next = count;
                desc_next      = (op_in == OP_READ_DSC);
              end
            end
            default: begin
              out_valid_next = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          out_val_next    = desc ? stat.tail : stat.head;
          out_status_next = ST_ENTRY;
          out_last_next   = (remaining == count_t'(1));
          ctrl.cmd        = desc ? CMD_ROT_DN : CMD_ROT_UP;
          remaining_next  = remaining - count_t'(1);
          // after count rotations the chain is back in order
          if (remaining == count_t'(1)) state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    remaining  <= remaining_next;
    desc       <= desc_next;
    out_val    <= out_val_next;
    out_status <= out_status_next;
    out_last   <= out_last_next;
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = DATA_W'($unsigned(out_val));
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

endmodule

// ===== tb/sv/tb_sorted_list_insert_delete_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_delete_unit
// Self-checking bench for the sorted list unit. A directed table covers the
// empty, full and no-match cases, the value extremes and both readout orders.
// A long random run then alternates between mixed, draining and filling
// phases. Every accepted input transfer goes through a local sorted-list
// predictor. Every output transfer is compared with the oldest expected
// result.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_delete_unit;
  import slid_pkg::*;

  localparam int ITEMS       = 396;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = DEPTH + 8;
  localparam int NUM_ROWS    = 22;

  typedef struct packed {
    value_t  val;
    status_t st;
    logic    lst;
  } result_t;

  // One directed row; reps > 1 sends val, val+1, ... in turn
  typedef struct packed {
    op_t        op;
    value_t     val;
    logic [4:0] reps;
    logic       typed;
    status_t    st;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic [1:0]        s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [2:0]        m_tuser;
  logic              m_tlast;

  // sideband that travels with the item being offered
  logic    drv_typed = 1'b0;
  status_t drv_st = ST_INSERTED;
  logic    quiet = 1'b0;

  value_t  sorted_vals[$];
  result_t expected_results[$];
  int      mismatches = 0;
  int      items_taken = 0;
  int      results_seen = 0;
  int      status_seen[6] = '{default: 0};
  int      cycles = 0;

  row_t plan [0:NUM_ROWS-1] = '{
    '{OP_READ_ASC, 32'h0000_0000, 5'd1,  1'b1, ST_EMPTY},
    '{OP_READ_DSC, 32'h0000_1234, 5'd1,  1'b1, ST_EMPTY},
    '{OP_DELETE,   32'h0000_0005, 5'd1,  1'b1, ST_NOTFOUND},
    '{OP_INSERT,   32'h7fff_ffff, 5'd1,  1'b1, ST_INSERTED},
    '{OP_INSERT,   32'h8000_0000, 5'd1,  1'b1, ST_INSERTED},
    '{OP_INSERT,   32'h0000_0000, 5'd1,  1'b1, ST_INSERTED},
    '{OP_INSERT,   32'hffff_ffff, 5'd1,  1'b1, ST_INSERTED},
    '{OP_INSERT,   32'h0000_0000, 5'd1,  1'b1, ST_INSERTED},
    '{OP_READ_ASC, 32'h0000_0000, 5'd1,  1'b0, ST_ENTRY},
    '{OP_READ_DSC, 32'h0000_0000, 5'd1,  1'b0, ST_ENTRY},
    '{OP_DELETE,   32'h0000_0000, 5'd1,  1'b1, ST_DELETED},
    '{OP_DELETE,   32'h0000_0007, 5'd1,  1'b1, ST_NOTFOUND},
    '{OP_DELETE,   32'h8000_0000, 5'd1,  1'b1, ST_DELETED},
    '{OP_DELETE,   32'h8000_0000, 5'd1,  1'b1, ST_NOTFOUND},
    '{OP_INSERT,   32'h0000_0064, 5'd13, 1'b0, ST_INSERTED},
    '{OP_INSERT,   32'h5555_5555, 5'd1,  1'b1, ST_FULL},
    '{OP_INSERT,   32'haaaa_aaaa, 5'd1,  1'b1, ST_FULL},
    '{OP_READ_ASC, 32'h0000_0000, 5'd1,  1'b0, ST_ENTRY},
    '{OP_READ_DSC, 32'hffff_ffff, 5'd1,  1'b0, ST_ENTRY},
    '{OP_DELETE,   32'h7fff_ffff, 5'd1,  1'b1, ST_DELETED},
    '{OP_INSERT,   32'h8000_0000, 5'd1,  1'b1, ST_INSERTED},
    '{OP_READ_ASC, 32'h0000_0000, 5'd1,  1'b0, ST_ENTRY}
  };

  sorted_list_insert_delete_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sorted-list predictor: updates sorted_vals and returns the results of one op
  function automatic void list_step(input op_t op, input value_t v, ref result_t res[$]);
    int pos;
    int n;
    n = sorted_vals.size();
    pos = 0;
    res.delete();
    case (op)
      OP_INSERT: begin
        if (n >= DEPTH) begin
          res.push_back('{v, ST_FULL, 1'b1});
        end else begin
          // new value goes ahead of any equal entries
          while (pos < n && sorted_vals[pos] < v) pos++;
          sorted_vals.insert(pos, v);
          res.push_back('{v, ST_INSERTED, 1'b1});
        end
      end
      OP_DELETE: begin
        while (pos < n && sorted_vals[pos] != v) pos++;
        if (pos < n) begin
          sorted_vals.delete(pos);
          res.push_back('{v, ST_DELETED, 1'b1});
        end else begin
          res.push_back('{v, ST_NOTFOUND, 1'b1});
        end
      end
      default: begin
        if (n == 0) begin
          res.push_back('{value_t'(0), ST_EMPTY, 1'b1});
        end else begin
          for (int i = 0; i < n; i++) begin
            res.push_back('{sorted_vals[(op == OP_READ_ASC) ? i : n - 1 - i], ST_ENTRY,
                            logic'(i == n - 1)});
          end
        end
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected value %0d status %0d last %0b, got value %0d status %0d last %0b",
               $realtime, what, want.val, want.st, want.lst, got.val, got.st, got.lst);
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t res_q[$];
    result_t got;
    result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        list_step(op_t'(s_tuser), value_t'(s_tdata[VALUE_BITS-1:0]), res_q);
        if (drv_typed) begin
          want.val = (drv_st == ST_EMPTY) ? value_t'(0) : value_t'(s_tdata[VALUE_BITS-1:0]);
          want.st  = drv_st;
          want.lst = 1'b1;
          res_q.delete();
          res_q.push_back(want);
        end
        foreach (res_q[k]) begin
          expected_results.push_back(res_q[k]);
          status_seen[int'(res_q[k].st)]++;
        end
        items_taken++;
      end
      if (m_tvalid && m_tready) begin
        got = '{value_t'(m_tdata[VALUE_BITS-1:0]), status_t'(m_tuser), m_tlast};
        results_seen++;
        if (expected_results.size() == 0) begin
          flag_mismatch("result with nothing pending", got, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) flag_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_sorted_list_insert_delete_unit: done, errors");
      $finish;
    end
  end

  task automatic send_item(input op_t op, input value_t v, input bit typed, input status_t est);
    if (!quiet && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tuser   <= op;
    s_tdata   <= DATA_W'(unsigned'(v));
    drv_typed <= typed;
    drv_st    <= est;
    do @(posedge clk); while (!s_tready);
  endtask

  // one edge first so the results of the last accepted item are queued
  task automatic wait_drained();
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return value_t'(32'h8000_0000);
          1: return value_t'(32'h7fff_ffff);
          2: return value_t'(0);
          default: return value_t'(-1);
        endcase
      end
      // narrow range so duplicates are common
      1, 2, 3: return value_t'(int'($urandom_range(15)) - 8);
      default: return value_t'($urandom());
    endcase
  endfunction

  // drain phase favors deletes, fill phase favors inserts
  function automatic op_t pick_op(input int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      1: return (r < 70) ? OP_DELETE : (r < 80) ? OP_INSERT : (r < 90) ? OP_READ_ASC
                : OP_READ_DSC;
      3: return (r < 70) ? OP_INSERT : (r < 80) ? OP_DELETE : (r < 90) ? OP_READ_ASC
                : OP_READ_DSC;
      default: return (r < 40) ? OP_INSERT : (r < 70) ? OP_DELETE : (r < 85) ? OP_READ_ASC
                : OP_READ_DSC;
    endcase
  endfunction

  initial begin : stimulus
    op_t    op;
    value_t v;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      for (int k = 0; k < int'(plan[r].reps); k++) begin
        send_item(plan[r].op, value_t'(plan[r].val + k), plan[r].typed, plan[r].st);
      end
    end
    s_tvalid <= 1'b0;
    wait_drained();

    for (int i = 0; i < ITEMS; i++) begin
      if (i == 215) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
      quiet = (i >= 200 && i < 290);
      op = pick_op((i / 40) % 4);
      if (op == OP_DELETE && sorted_vals.size() > 0 && $urandom_range(99) < 65) begin
        v = sorted_vals[$urandom_range(sorted_vals.size() - 1)];
      end else begin
        v = pick_value();
      end
      send_item(op, v, 1'b0, ST_ENTRY);
    end
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d input transfers and %0d result transfers in %0d cycles",
             items_taken, results_seen, cycles);
    $display("  inserted %0d, deleted %0d, not found %0d, full %0d, empty %0d, entries %0d",
             status_seen[ST_INSERTED], status_seen[ST_DELETED], status_seen[ST_NOTFOUND],
             status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_ENTRY]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_sorted_list_insert_delete_unit: done, clean");
    end else begin
      $display("tb_sorted_list_insert_delete_unit: done, errors");
    end
    $finish;
  end

endmodule
